/* rtl/core/gbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg
// shared constants and types for the greedy box suppression block
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned MaxKeptDefault   = 256;
  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned IndexBits        = 12;
  localparam int unsigned ClassBits        = 7;
  localparam int unsigned ThreshBits       = 9;
  localparam logic [ThreshBits-1:0] ThreshReset = 9'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

/* rtl/core/gbs_iou_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_iou_unit
// pipelined pair test: overlaps and edge lengths, then products, then compare
// one pair per cycle
// ----------------------------------------------------------------------------
module gbs_iou_unit #(
  parameter int unsigned CoordBits = gbs_pkg::CoordBitsDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            valid_i,
  input  wire [4*CoordBits-1:0]          cand_i,
  input  wire [4*CoordBits-1:0]          kept_i,
  input  wire [gbs_pkg::ThreshBits-1:0]  thresh_i,
  output logic                           valid_o,
  output logic                           close_o
);
  localparam int unsigned AW = 2*CoordBits;
  localparam int unsigned UW = AW + 1;
  localparam int unsigned TW = gbs_pkg::ThreshBits;

  logic [CoordBits-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic [CoordBits-1:0] lox, hix, loy, hiy;
  logic [CoordBits-1:0] ox_d, oy_d, ewa_d, eha_d, ewb_d, ehb_d;
  logic [CoordBits-1:0] ox_q, oy_q, ewa_q, eha_q, ewb_q, ehb_q;
  logic [AW-1:0] inter_q, area_a_q, area_b_q;
  logic [UW-1:0] uni;
  logic [AW+7:0] lhs_q;
  logic [UW+TW-1:0] rhs_q;
  logic [UW-1:0] uni_q;
  logic [2:0] v_q;

  assign {ay1, ax1, ay0, ax0} = cand_i;
  assign {by1, bx1, by0, bx0} = kept_i;

  always_comb begin
    lox   = (ax0 > bx0) ? ax0 : bx0;
    hix   = (ax1 < bx1) ? ax1 : bx1;
    loy   = (ay0 > by0) ? ay0 : by0;
    hiy   = (ay1 < by1) ? ay1 : by1;
    ox_d  = (hix >= lox) ? hix - lox : '0;
    oy_d  = (hiy >= loy) ? hiy - loy : '0;
    ewa_d = (ax1 >= ax0) ? ax1 - ax0 : '0;
    eha_d = (ay1 >= ay0) ? ay1 - ay0 : '0;
    ewb_d = (bx1 >= bx0) ? bx1 - bx0 : '0;
    ehb_d = (by1 >= by0) ? by1 - by0 : '0;
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d; oy_q <= oy_d;
    ewa_q <= ewa_d; eha_q <= eha_d; ewb_q <= ewb_d; ehb_q <= ehb_d;
    inter_q  <= ox_q * oy_q;
    area_a_q <= ewa_q * eha_q;
    area_b_q <= ewb_q * ehb_q;
  end

  // union never underflows since inter fits in either area
  assign uni = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};

  always_ff @(posedge clk_i) begin
    lhs_q <= {inter_q, 8'd0};
    rhs_q <= {{TW{1'b0}}, uni} * {{UW{1'b0}}, thresh_i};
    uni_q <= uni;
  end

  assign close_o = (uni_q != '0) && ({{(UW+TW-AW-8){1'b0}}, lhs_q} > rhs_q);
  assign valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/gbs_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_store
// kept box memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbs_store #(
  parameter int unsigned MaxKept   = gbs_pkg::MaxKeptDefault,
  parameter int unsigned CoordBits = gbs_pkg::CoordBitsDefault,
  localparam int unsigned AddrBits = (MaxKept > 1) ? $clog2(MaxKept) : 1
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [AddrBits-1:0]      waddr_i,
  input  wire [4*CoordBits-1:0]   wdata_i,
  input  wire [AddrBits-1:0]      raddr_i,
  output logic [4*CoordBits-1:0]  rdata_o
);
  logic [4*CoordBits-1:0] mem_q [MaxKept];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/greedy_box_suppression.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_suppression
// greedy non-maximum suppression over a stream of score-sorted boxes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one candidate per transfer, m_axis one verdict per
//   candidate, cfg writes the iou threshold (units of 1/256) while idle
// operation:
//   each candidate is tested against every kept box of the current set,
//   one stored box read from the kept memory per cycle into a three stage
//   overlap/product/compare pipe; the scan stops at the first suppressor
// latency and throughput:
//   the scan time grows with the number of kept boxes and is set by the
//   memory read port and the pair pipe; the next transfer is taken only
//   after the verdict for the current candidate is issued
// reset:
//   kept count cleared, threshold 128; memory contents undefined and never
//   read before written
// stall:
//   the verdict sits in an output register; the next candidate is still
//   taken and scanned, and its verdict is held back until the receiver
//   takes the waiting one
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
  parameter int unsigned MaxKept   = gbs_pkg::MaxKeptDefault,
  parameter int unsigned CoordBits = gbs_pkg::CoordBitsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // box_index, class_id, x_min, y_min, x_max, y_max (low bit up)
  input  wire  [87:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // out_index, out_class, kept, overflow (low bit up)
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [8:0]  cfg_data_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o
);
  localparam int unsigned AddrBits = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned CntBits  = $clog2(MaxKept + 1);
  localparam int unsigned IB = gbs_pkg::IndexBits;
  localparam int unsigned CB = gbs_pkg::ClassBits;

  gbs_pkg::state_e state_q, state_d;

  logic [gbs_pkg::ThreshBits-1:0] thresh_q;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] rptr_q, rptr_d;   // next entry to issue
  logic [CntBits-1:0] done_q, done_d;   // results returned from pipe
  logic [4*CoordBits-1:0] cand_q;
  logic [IB-1:0] idx_q;
  logic [CB-1:0] cls_q;
  logic last_q, supp_q, supp_d;
  logic [4*CoordBits-1:0] rdata;
  logic rd_issue, rd_v_q, pv, pclose;
  logic we;
  logic out_load;
  logic ovf;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= gbs_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == gbs_pkg::ST_IDLE);

  // capture candidate, only low coordinate bits are used
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      idx_q  <= s_axis_tdata[IB-1:0];
      cls_q  <= s_axis_tdata[IB+CB-1:IB];
      cand_q <= {s_axis_tdata[66+CoordBits:67], s_axis_tdata[50+CoordBits:51],
                 s_axis_tdata[34+CoordBits:35], s_axis_tdata[18+CoordBits:19]};
      last_q <= s_axis_tlast;
    end
  end

  assign rd_issue = (state_q == gbs_pkg::ST_READ) && (rptr_q < count_q) && !supp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= rd_issue;
    end
  end

  gbs_store #(.MaxKept(MaxKept), .CoordBits(CoordBits)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrBits-1:0]),
    .wdata_i (cand_q),
    .raddr_i (rptr_q[AddrBits-1:0]),
    .rdata_o (rdata)
  );

  gbs_iou_unit #(.CoordBits(CoordBits)) u_iou (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_v_q),
    .cand_i   (cand_q),
    .kept_i   (rdata),
    .thresh_i (thresh_q),
    .valid_o  (pv),
    .close_o  (pclose)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbs_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = gbs_pkg::ST_READ;
      gbs_pkg::ST_READ: if (supp_q || rptr_q >= count_q) state_d = gbs_pkg::ST_CMP;
      gbs_pkg::ST_CMP:  if (done_q == rptr_q && !rd_v_q) state_d = gbs_pkg::ST_DONE;
      // wait until the output register is free
      gbs_pkg::ST_DONE: if (!m_axis_tvalid || m_axis_tready) state_d = gbs_pkg::ST_IDLE;
      default:          state_d = gbs_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rptr_d   = rptr_q;
    done_d   = done_q;
    supp_d   = supp_q;
    count_d  = count_q;
    we       = 1'b0;
    out_load = 1'b0;
    ovf      = 1'b0;
    if (rd_issue) rptr_d = rptr_q + 1'b1;
    if (pv) begin
      done_d = done_q + 1'b1;
      if (pclose) supp_d = 1'b1;
    end
    unique case (state_q)
      gbs_pkg::ST_IDLE: begin
        rptr_d = '0;
        done_d = '0;
        supp_d = 1'b0;
      end
      gbs_pkg::ST_DONE: begin
        ovf = !supp_q && (count_q == CntBits'(MaxKept));
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          if (!supp_q && !ovf) begin
            we = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (last_q) count_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbs_pkg::ST_IDLE;
      count_q <= '0;
      rptr_q  <= '0;
      done_q  <= '0;
      supp_q  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rptr_q  <= rptr_d;
      done_q  <= done_d;
      supp_q  <= supp_d;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {3'd0, ovf, !supp_q, cls_q, idx_q};
      m_axis_tlast <= last_q;
    end
  end
endmodule
`default_nettype wire
